// ===== sv/a2a_addr_pkg.sv =====
// Shared widths, register indexes and peer-order codes for the all-to-all addresser.
package a2a_addr_pkg;

  // field widths
  localparam int MODE_W     = 2;
  localparam int RANK_W     = 10;
  localparam int SIZE_W     = 11;
  localparam int PE_W       = 16;
  localparam int LPS_W      = 4;
  localparam int STEP_W     = 17;
  localparam int ELEM_W     = 16;
  localparam int OFF_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // internal datapath widths
  localparam int DIFF_W     = SIZE_W + 1;
  localparam int PROD_W     = RANK_W + ELEM_W;
  localparam int IDX_W      = PROD_W + 1;
  localparam int OFFP_W     = IDX_W + STEP_W;
  localparam int PE_SUM_W   = RANK_W + (2 ** LPS_W - 1) + 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PEER_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MY_RANK        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEAM_SIZE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_PE_STRIDE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_STEP_BYTES = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_STEP_BYTES = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMS_PER_PEER = 3'd7;

  // peer order codes
  localparam logic [MODE_W-1:0] MODE_SHIFT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_XOR      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COLOUR   = 2'd2;
  // no peer order: only the self copy goes out
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

endpackage

// ===== sv/alltoall_strided_transfer_addresser.sv =====
// All-to-all strided transfer addresser: six-stage descriptor pipeline with config registers.
// Takes one (round, element_index) beat per cycle unless stalled, and returns one descriptor
// beat per input, in order. Stage 1 checks the team and forms the partner sums, stage 2
// reduces them modulo the team or colour count, stage 3 picks the partner by peer_mode,
// stage 4 holds the rank-times-block multiplies and the PE sum, stage 5 adds the element,
// stage 6 holds the 27x17 offset multiplies. Each stage has its own valid bit and loads
// whenever it is empty or the stage after it moves, so a held output only blocks as far
// back as the pipe is full. Configuration is to be written only while no beat is in flight.
module alltoall_strided_transfer_addresser
  import a2a_addr_pkg::*;
#(
  parameter int MAX_PES     = 1024,
  parameter int OFFSET_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [RANK_W-1:0]     round,
  input  logic [ELEM_W-1:0]     element_index,
  // descriptor channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  transfer_valid,
  output logic                  local_copy,
  output logic [RANK_W-1:0]     peer_rank,
  output logic [PE_W-1:0]       target_pe,
  output logic [OFF_W-1:0]      src_offset,
  output logic [OFF_W-1:0]      dst_offset,
  output logic                  range_error
);

  localparam int MAXP_W   = 17;
  localparam logic [MAXP_W-1:0] MAX_PES_W = MAXP_W'(MAX_PES);
  localparam int LIM_BITS = (OFFSET_BITS < OFF_W) ? OFFSET_BITS : OFF_W;

  // configuration registers
  logic [MODE_W-1:0] peer_mode;
  logic [RANK_W-1:0] my_rank;
  logic [SIZE_W-1:0] team_count;
  logic [PE_W-1:0]   first_pe;
  logic [LPS_W-1:0]  log_pe_stride;
  logic [STEP_W-1:0] dst_step_bytes;
  logic [STEP_W-1:0] src_step_bytes;
  logic [ELEM_W-1:0] elems_per_peer;

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_mode      <= MODE_SHIFT;
      my_rank        <= '0;
      team_count     <= SIZE_W'(1);
      first_pe       <= '0;
      log_pe_stride  <= '0;
      dst_step_bytes <= STEP_W'(1);
      src_step_bytes <= STEP_W'(1);
      elems_per_peer <= ELEM_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PEER_MODE:      peer_mode      <= cfg_data[MODE_W-1:0];
        REG_MY_RANK:        my_rank        <= cfg_data[RANK_W-1:0];
        REG_TEAM_SIZE:      team_count     <= cfg_data[SIZE_W-1:0];
        REG_FIRST_PE:       first_pe       <= cfg_data[PE_W-1:0];
        REG_LOG_PE_STRIDE:  log_pe_stride  <= cfg_data[LPS_W-1:0];
        REG_DST_STEP_BYTES: dst_step_bytes <= cfg_data[STEP_W-1:0];
        REG_SRC_STEP_BYTES: src_step_bytes <= cfg_data[STEP_W-1:0];
        REG_ELEMS_PER_PEER: elems_per_peer <= cfg_data[ELEM_W-1:0];
        default:            peer_mode      <= peer_mode;
      endcase
    end
  end

  // per-stage valid bits and load enables
  logic v1, v2, v3, v4, v5, v6;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  assign ld6      = !v6 || out_ready;
  assign ld5      = !v5 || ld6;
  assign ld4      = !v4 || ld5;
  assign ld3      = !v3 || ld4;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
      if (ld5) v5 <= v4;
      if (ld6) v6 <= v5;
    end
  end

  // stage 1: team checks, shift sum, xor, colour count, round minus rank
  logic              bad_in;
  logic [SIZE_W-1:0] sum_in;
  logic [SIZE_W-1:0] colours_in;
  logic [DIFF_W-1:0] diff_in;

  assign bad_in = (team_count == '0) || (MAXP_W'(team_count) > MAX_PES_W) ||
                  ({1'b0, my_rank} >= team_count) || ({1'b0, round} >= team_count) ||
                  (element_index >= elems_per_peer);
  assign sum_in     = {1'b0, my_rank} + {1'b0, round};
  assign colours_in = team_count - {{(SIZE_W-1){1'b0}}, ~team_count[0]};
  assign diff_in    = {2'b00, round} - {2'b00, my_rank};

  logic [RANK_W-1:0] s1_rnd;
  logic [ELEM_W-1:0] s1_elem;
  logic              s1_bad;
  logic [SIZE_W-1:0] s1_sum;
  logic [RANK_W-1:0] s1_xor;
  logic [SIZE_W-1:0] s1_colours;
  logic [DIFF_W-1:0] s1_diff;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_rnd     <= round;
      s1_elem    <= element_index;
      s1_bad     <= bad_in;
      s1_sum     <= sum_in;
      s1_xor     <= round ^ my_rank;
      s1_colours <= colours_in;
      s1_diff    <= diff_in;
    end
  end

  // stage 2: modulo reductions and raw colour partner
  logic [SIZE_W-1:0] shift_peer;
  logic              xor_ok;
  logic [DIFF_W-1:0] col_c12;
  logic [DIFF_W-1:0] col_va;
  logic [DIFF_W-1:0] col_hsum;
  logic [SIZE_W-1:0] col_h;
  logic [SIZE_W-1:0] col_vb;
  logic [SIZE_W-1:0] col_v;
  logic              col_me_lt;

  always_comb begin
    shift_peer = (s1_sum >= team_count) ? (s1_sum - team_count) : s1_sum;
    xor_ok     = {1'b0, s1_xor} < team_count;
    col_c12    = {1'b0, s1_colours};
    col_me_lt  = {1'b0, my_rank} < s1_colours;
    // (round - rank) mod colours, difference known to lie in (-colours, 2*colours)
    if (s1_diff[DIFF_W-1]) begin
      col_va = s1_diff + col_c12;
    end else if (s1_diff >= col_c12) begin
      col_va = s1_diff - col_c12;
    end else begin
      col_va = s1_diff;
    end
    // last rank of an even team: half-round schedule
    col_hsum = {2'b00, s1_rnd} + col_c12;
    col_h    = col_hsum[DIFF_W-1:1];
    col_vb   = (col_h == s1_colours) ? '0 : col_h;
    if (col_me_lt) begin
      col_v = col_va[SIZE_W-1:0];
    end else if (s1_rnd[0]) begin
      col_v = col_vb;
    end else begin
      col_v = {2'b00, s1_rnd[RANK_W-1:1]};
    end
  end

  logic [RANK_W-1:0] s2_rnd;
  logic [ELEM_W-1:0] s2_elem;
  logic              s2_bad;
  logic [SIZE_W-1:0] s2_shift_peer;
  logic [RANK_W-1:0] s2_xor;
  logic              s2_xor_ok;
  logic [SIZE_W-1:0] s2_cv;
  logic [SIZE_W-1:0] s2_colours;

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_rnd        <= s1_rnd;
      s2_elem       <= s1_elem;
      s2_bad        <= s1_bad;
      s2_shift_peer <= shift_peer;
      s2_xor        <= s1_xor;
      s2_xor_ok     <= xor_ok;
      s2_cv         <= col_v;
      s2_colours    <= s1_colours;
    end
  end

  // stage 3: colour self-pairing fixup and partner select
  logic              c_self;
  logic [SIZE_W-1:0] c_peer;
  logic              c_ok;
  logic [SIZE_W-1:0] sel_peer;
  logic              sel_ok;

  always_comb begin
    c_self   = s2_cv == {1'b0, my_rank};
    c_peer   = c_self ? s2_colours : s2_cv;
    c_ok     = !(c_self && team_count[0]) && (c_peer < team_count);
    sel_peer = {1'b0, my_rank};
    sel_ok   = 1'b1;
    priority if (s2_bad) begin
      sel_ok = 1'b0;
    end else if (s2_rnd == '0) begin
      sel_peer = {1'b0, my_rank};
    end else begin
      unique case (peer_mode)
        MODE_SHIFT: sel_peer = s2_shift_peer;
        MODE_XOR: begin
          sel_peer = {1'b0, s2_xor};
          sel_ok   = s2_xor_ok;
        end
        MODE_COLOUR: begin
          sel_peer = c_peer;
          sel_ok   = c_ok;
        end
        default: sel_ok = 1'b0;
      endcase
    end
  end

  logic [ELEM_W-1:0] s3_elem;
  logic              s3_ok;
  logic              s3_local;
  logic [RANK_W-1:0] s3_peer;

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_elem  <= s2_elem;
      s3_ok    <= sel_ok;
      s3_local <= sel_ok && (s2_rnd == '0);
      s3_peer  <= sel_peer[RANK_W-1:0];
    end
  end

  // stage 4: block base multiplies and target PE sum
  logic [ELEM_W-1:0]   s4_elem;
  logic                s4_ok;
  logic                s4_local;
  logic [RANK_W-1:0]   s4_peer;
  logic [PE_SUM_W-1:0] s4_pe_sum;
  logic [PROD_W-1:0]   s4_prod_s;
  logic [PROD_W-1:0]   s4_prod_d;

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_elem   <= s3_elem;
      s4_ok     <= s3_ok;
      s4_local  <= s3_local;
      s4_peer   <= s3_peer;
      s4_pe_sum <= PE_SUM_W'(first_pe) + (PE_SUM_W'(s3_peer) << log_pe_stride);
      s4_prod_s <= PROD_W'(s3_peer) * PROD_W'(elems_per_peer);
      s4_prod_d <= PROD_W'(my_rank) * PROD_W'(elems_per_peer);
    end
  end

  // stage 5: add element within block
  logic              s5_ok;
  logic              s5_local;
  logic [RANK_W-1:0] s5_peer;
  logic [PE_W-1:0]   s5_pe;
  logic              s5_pe_err;
  logic [IDX_W-1:0]  s5_idx_s;
  logic [IDX_W-1:0]  s5_idx_d;

  always_ff @(posedge clk) begin
    if (ld5) begin
      s5_ok     <= s4_ok;
      s5_local  <= s4_local;
      s5_peer   <= s4_peer;
      s5_pe     <= s4_pe_sum[PE_W-1:0];
      s5_pe_err <= |s4_pe_sum[PE_SUM_W-1:PE_W];
      s5_idx_s  <= IDX_W'(s4_prod_s) + IDX_W'(s4_elem);
      s5_idx_d  <= IDX_W'(s4_prod_d) + IDX_W'(s4_elem);
    end
  end

  // stage 6: byte offset multiplies, output register
  logic              s6_ok;
  logic              s6_local;
  logic [RANK_W-1:0] s6_peer;
  logic [PE_W-1:0]   s6_pe;
  logic              s6_pe_err;
  logic [OFFP_W-1:0] s6_soff;
  logic [OFFP_W-1:0] s6_doff;

  always_ff @(posedge clk) begin
    if (ld6) begin
      s6_ok     <= s5_ok;
      s6_local  <= s5_local;
      s6_peer   <= s5_peer;
      s6_pe     <= s5_pe;
      s6_pe_err <= s5_pe_err;
      s6_soff   <= OFFP_W'(s5_idx_s) * OFFP_W'(src_step_bytes);
      s6_doff   <= OFFP_W'(s5_idx_d) * OFFP_W'(dst_step_bytes);
    end
  end

  // offset overflow against the configured offset width
  logic [63:0] soff_wide;
  logic [63:0] doff_wide;
  logic        off_err;

  assign soff_wide = 64'(s6_soff);
  assign doff_wide = 64'(s6_doff);
  assign off_err   = ((soff_wide >> LIM_BITS) != 64'd0) || ((doff_wide >> LIM_BITS) != 64'd0);

  // descriptor fields read zero when no transfer
  assign out_valid      = v6;
  assign transfer_valid = s6_ok;
  assign local_copy     = s6_ok && s6_local;
  assign peer_rank      = s6_ok ? s6_peer : '0;
  assign target_pe      = s6_ok ? s6_pe : '0;
  assign src_offset     = s6_ok ? OFF_W'(s6_soff) : '0;
  assign dst_offset     = s6_ok ? OFF_W'(s6_doff) : '0;
  assign range_error    = s6_ok && (s6_pe_err || off_err);

  // an empty output stage lets the whole pipe advance
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // self copy always names this PE
  assert property (@(posedge clk) disable iff (rst)
    out_valid && local_copy |-> peer_rank == my_rank)
    else $error("self copy with foreign peer rank");

  // a granted transfer names a team member
  assert property (@(posedge clk) disable iff (rst)
    out_valid && transfer_valid |-> {1'b0, peer_rank} < team_count)
    else $error("transfer partner outside team");

endmodule

// ===== bench/a2a_addr_checker.sv =====
// Descriptor predictor and scoreboard for the all-to-all strided transfer addresser.
module a2a_addr_checker
  import a2a_addr_pkg::*;
#(
  parameter int MAX_PES     = 1024,
  parameter int OFFSET_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [RANK_W-1:0]     round,
  input  logic [ELEM_W-1:0]     element_index,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  transfer_valid,
  input  logic                  local_copy,
  input  logic [RANK_W-1:0]     peer_rank,
  input  logic [PE_W-1:0]       target_pe,
  input  logic [OFF_W-1:0]      src_offset,
  input  logic [OFF_W-1:0]      dst_offset,
  input  logic                  range_error,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              transfer_valid;
    logic              local_copy;
    logic [RANK_W-1:0] peer_rank;
    logic [PE_W-1:0]   target_pe;
    logic [OFF_W-1:0]  src_offset;
    logic [OFF_W-1:0]  dst_offset;
    logic              range_error;
  } descriptor_t;

  localparam longint unsigned OFF_LIMIT =
    (OFFSET_BITS >= 48) ? 64'hFFFF_FFFF_FFFF : ((64'd1 << OFFSET_BITS) - 1);

  // shadow copy of the configuration registers
  logic [MODE_W-1:0] cur_mode;
  logic [RANK_W-1:0] cur_rank;
  logic [SIZE_W-1:0] cur_team;
  logic [PE_W-1:0]   cur_first_pe;
  logic [LPS_W-1:0]  cur_lps;
  logic [STEP_W-1:0] cur_dst_step;
  logic [STEP_W-1:0] cur_src_step;
  logic [ELEM_W-1:0] cur_epp;

  descriptor_t pending_descs[$];

  // Edge-colouring partner; returns 0 when this PE sits out the round.
  function automatic bit colour_peer(input longint unsigned rnd, input longint unsigned me,
                                     input longint unsigned n, output longint unsigned pr);
    bit odd;
    longint unsigned colours, v;
    odd = n[0];
    colours = odd ? n : n - 1;
    pr = 0;
    if (me < colours) begin
      v = (rnd + colours - me) % colours;
    end else if (rnd[0]) begin
      v = ((rnd + colours) / 2) % colours;
    end else begin
      v = rnd / 2;
    end
    if (v == me) begin
      if (odd) return 1'b0;
      v = colours;
    end
    pr = v;
    return 1'b1;
  endfunction

  // Descriptor for one (round, element) request under the current settings.
  function automatic descriptor_t predict_descriptor(input logic [RANK_W-1:0] rnd_in,
                                                     input logic [ELEM_W-1:0] elem_in);
    descriptor_t d;
    longint unsigned rnd, elem, me, n, epp, peer, pe, soff, doff;
    bit ok;
    d = '0;
    rnd = rnd_in;
    elem = elem_in;
    me = cur_rank;
    n = cur_team;
    epp = cur_epp;
    peer = 0;
    ok = 1'b1;
    if (n == 0 || n > MAX_PES || me >= n || rnd >= n || elem >= epp) return d;
    if (rnd == 0) begin
      peer = me;
    end else begin
      case (cur_mode)
        MODE_SHIFT: peer = (me + rnd) % n;
        MODE_XOR: begin
          peer = rnd ^ me;
          ok = peer < n;
        end
        MODE_COLOUR: ok = colour_peer(rnd, me, n, peer) && peer < n;
        default: ok = 1'b0;
      endcase
    end
    if (!ok) return d;
    pe   = longint'(cur_first_pe) + (peer << cur_lps);
    soff = (peer * epp + elem) * longint'(cur_src_step);
    doff = (me * epp + elem) * longint'(cur_dst_step);
    d.transfer_valid = 1'b1;
    d.local_copy     = (rnd == 0);
    d.peer_rank      = peer[RANK_W-1:0];
    d.target_pe      = pe[PE_W-1:0];
    d.src_offset     = soff[OFF_W-1:0];
    d.dst_offset     = doff[OFF_W-1:0];
    d.range_error    = (pe > 64'hFFFF) || (soff > OFF_LIMIT) || (doff > OFF_LIMIT);
    return d;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    descriptor_t want;
    if (rst) begin
      cur_mode     = MODE_SHIFT;
      cur_rank     = '0;
      cur_team     = SIZE_W'(1);
      cur_first_pe = '0;
      cur_lps      = '0;
      cur_dst_step = STEP_W'(1);
      cur_src_step = STEP_W'(1);
      cur_epp      = ELEM_W'(1);
      mismatches   = 0;
      pending_descs.delete();
    end else begin
      // register writes land at the same edge as in the block
      if (cfg_write) begin
        case (cfg_index)
          REG_PEER_MODE:      cur_mode     = cfg_data[MODE_W-1:0];
          REG_MY_RANK:        cur_rank     = cfg_data[RANK_W-1:0];
          REG_TEAM_SIZE:      cur_team     = cfg_data[SIZE_W-1:0];
          REG_FIRST_PE:       cur_first_pe = cfg_data[PE_W-1:0];
          REG_LOG_PE_STRIDE:  cur_lps      = cfg_data[LPS_W-1:0];
          REG_DST_STEP_BYTES: cur_dst_step = cfg_data[STEP_W-1:0];
          REG_SRC_STEP_BYTES: cur_src_step = cfg_data[STEP_W-1:0];
          default:            cur_epp      = cfg_data[ELEM_W-1:0];
        endcase
      end
      // request beat: queue its expected descriptor
      if (in_valid && in_ready)
        pending_descs.push_back(predict_descriptor(round, element_index));
      // descriptor beat: compare with the oldest expectation
      if (out_valid && out_ready) begin
        if (pending_descs.size() == 0) begin
          if (mismatches < 10) $display("%0t: descriptor beat with none expected", $realtime);
          mismatches++;
        end else begin
          want = pending_descs.pop_front();
          check_field("transfer_valid", 64'(want.transfer_valid), 64'(transfer_valid));
          check_field("local_copy", 64'(want.local_copy), 64'(local_copy));
          check_field("peer_rank", 64'(want.peer_rank), 64'(peer_rank));
          check_field("target_pe", 64'(want.target_pe), 64'(target_pe));
          check_field("src_offset", 64'(want.src_offset), 64'(src_offset));
          check_field("dst_offset", 64'(want.dst_offset), 64'(dst_offset));
          check_field("range_error", 64'(want.range_error), 64'(range_error));
        end
      end
    end
    outstanding = pending_descs.size();
  end

endmodule

// ===== bench/tb_alltoall_strided_transfer_addresser.sv =====
// Top of the addresser testbench: clock, reset, request stimulus, output stalls and verdict.
module tb_alltoall_strided_transfer_addresser;
  import a2a_addr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no beat on either channel before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [RANK_W-1:0]     round = '0;
  logic [ELEM_W-1:0]     element_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  transfer_valid;
  logic                  local_copy;
  logic [RANK_W-1:0]     peer_rank;
  logic [PE_W-1:0]       target_pe;
  logic [OFF_W-1:0]      src_offset;
  logic [OFF_W-1:0]      dst_offset;
  logic                  range_error;

  int mismatches;
  int outstanding;
  bit steady = 1'b0;
  int cfg_team = 1;
  int cfg_epp = 1;

  alltoall_strided_transfer_addresser uut (.*);

  a2a_addr_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // descriptor side: random back-pressure unless in a steady stretch
  always @(posedge clk) out_ready <= steady || ($urandom_range(0, 99) >= 36);

  // hang detection
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_config(input int mode, input int rank, input int team, input int fpe,
                            input int lps, input int dstep, input int sstep, input int epp);
    write_reg(REG_PEER_MODE, mode);
    write_reg(REG_MY_RANK, rank);
    write_reg(REG_TEAM_SIZE, team);
    write_reg(REG_FIRST_PE, fpe);
    write_reg(REG_LOG_PE_STRIDE, lps);
    write_reg(REG_DST_STEP_BYTES, dstep);
    write_reg(REG_SRC_STEP_BYTES, sstep);
    write_reg(REG_ELEMS_PER_PEER, epp);
    cfg_write <= 1'b0;
    cfg_team = team;
    cfg_epp  = epp;
  endtask

  // one request beat, with random idle cycles ahead of it
  task automatic send_beat(input int r, input int e);
    while (!steady && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    round         <= r[RANK_W-1:0];
    element_index <= e[ELEM_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and wait until every descriptor has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int mode, team, rank, lps, dstep, sstep, epp, kind, team_hi, r, e;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: self copy, round past the team, element past the block
    send_beat(0, 0);
    send_beat(1, 0);
    send_beat(0, 1);
    wait_drained();

    // largest team, top rank, widest strides: target PE overflows
    set_config(MODE_SHIFT, 1023, 1024, 65535, 15, 131071, 65536, 65535);
    send_beat(1023, 65534);
    send_beat(0, 0);
    send_beat(1, 65535);
    wait_drained();

    // xor order on a team that is not a power of two
    set_config(MODE_XOR, 999, 1000, 0, 0, 1, 1, 4);
    send_beat(25, 3);
    send_beat(3, 0);
    send_beat(1000, 0);
    wait_drained();

    // colour order, odd team: round 6 is this PE's idle round
    set_config(MODE_COLOUR, 3, 7, 40, 1, 4, 12, 2);
    send_beat(6, 1);
    send_beat(2, 0);
    wait_drained();

    // colour order, even team: own-colour partner maps to the last rank
    set_config(MODE_COLOUR, 2, 8, 100, 2, 16, 8, 2);
    send_beat(4, 0);
    send_beat(3, 1);
    wait_drained();
    write_reg(REG_MY_RANK, 7);
    cfg_write <= 1'b0;
    send_beat(1, 0);
    send_beat(2, 0);
    wait_drained();

    // unknown peer order only allows the self copy
    set_config(MODE_RESERVED, 0, 4, 9, 0, 2, 2, 1);
    send_beat(0, 0);
    send_beat(1, 0);
    wait_drained();

    // bad teams: empty, oversized, rank outside the team
    write_reg(REG_TEAM_SIZE, 0);
    cfg_write <= 1'b0;
    send_beat(0, 0);
    wait_drained();
    write_reg(REG_TEAM_SIZE, 2047);
    cfg_write <= 1'b0;
    send_beat(0, 0);
    wait_drained();
    write_reg(REG_TEAM_SIZE, 4);
    write_reg(REG_MY_RANK, 5);
    cfg_write <= 1'b0;
    send_beat(0, 0);
    wait_drained();

    // zero steps: first with an empty block, then with a block of three
    set_config(MODE_SHIFT, 1, 2, 7, 3, 0, 0, 0);
    send_beat(1, 0);
    wait_drained();
    write_reg(REG_ELEMS_PER_PEER, 3);
    cfg_write <= 1'b0;
    send_beat(1, 2);
    wait_drained();

    // random phases: fresh settings each, mostly in-range requests
    for (int p = 0; p < 12; p++) begin
      kind = $urandom_range(0, 9);
      mode = (kind < 3) ? MODE_SHIFT : (kind < 6) ? MODE_XOR :
             (kind < 9) ? MODE_COLOUR : MODE_RESERVED;
      kind = $urandom_range(0, 9);
      if (kind < 4) team = $urandom_range(1, 16);
      else if (kind < 6) team = 1 << $urandom_range(0, 10);
      else if (kind < 8) team = $urandom_range(1, 1024);
      else if (kind == 8) team = 1024;
      else team = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1025, 2047);
      if (team >= 1 && team <= 1024 && $urandom_range(0, 9) != 0)
        rank = $urandom_range(0, team - 1);
      else
        rank = $urandom_range(0, 1023);
      lps = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(0, 15);
      kind = $urandom_range(0, 9);
      dstep = (kind < 7) ? $urandom_range(1, 64) :
              (kind < 9) ? $urandom_range(1, 65536) : $urandom_range(0, 131071);
      kind = $urandom_range(0, 9);
      sstep = (kind < 7) ? $urandom_range(1, 64) :
              (kind < 9) ? $urandom_range(1, 65536) : $urandom_range(0, 131071);
      kind = $urandom_range(0, 9);
      if (kind < 6) epp = $urandom_range(1, 8);
      else if (kind < 8) epp = $urandom_range(1, 300);
      else if (kind == 8) epp = $urandom_range(1, 65535);
      else epp = $urandom_range(0, 1) ? 65535 : 0;
      set_config(mode, rank, team, $urandom_range(0, 65535), lps, dstep, sstep, epp);
      steady = (p == 4);
      team_hi = (cfg_team >= 1 && cfg_team <= 1024) ? cfg_team : 1024;
      for (int i = 0; i < 92; i++) begin
        // occasional full drain before the next request
        if ((p == 0 && i == 46) || $urandom_range(0, 59) == 0) wait_drained();
        if ($urandom_range(0, 99) < 85) begin
          r = $urandom_range(0, team_hi - 1);
          if (cfg_epp == 0) e = 0;
          else if ($urandom_range(0, 9) == 0) e = cfg_epp - 1;
          else e = $urandom_range(0, cfg_epp - 1);
        end else begin
          r = $urandom_range(0, 1023);
          e = $urandom_range(0, 65535);
        end
        send_beat(r, e);
      end
      wait_drained();
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
